// ----- src/terminal_line_edit_buffer_core_assert.svh -----
// assertion macros included by the line editor (tleb_back)
// TLEB_ASSERT checks a property at every clock edge outside reset
// TLEB_ASSERT_NEXT checks that a trigger is followed by a property in the next cycle
`ifndef TERMINAL_LINE_EDIT_BUFFER_CORE_ASSERT_SVH
`define TERMINAL_LINE_EDIT_BUFFER_CORE_ASSERT_SVH
`ifndef SYNTH
`define TLEB_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);
`define TLEB_ASSERT_NEXT(label, trig, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |=> (prop)) \
        else $error(msg);
`else
`define TLEB_ASSERT(label, prop, msg)
`define TLEB_ASSERT_NEXT(label, trig, prop, msg)
`endif
`endif

// ----- src/tleb_pkg.sv -----
package tleb_pkg;

    // cursor and length width
    localparam int CNT_W = 7;

    // key codes
    localparam logic [7:0] KEY_LF       = 8'd10;
    localparam logic [7:0] KEY_CR       = 8'd13;
    localparam logic [7:0] KEY_ESC      = 8'd27;
    localparam logic [7:0] KEY_SPACE    = 8'd32;
    localparam logic [7:0] KEY_THREE    = 8'h33;
    localparam logic [7:0] KEY_C        = 8'h43;
    localparam logic [7:0] KEY_D        = 8'h44;
    localparam logic [7:0] KEY_F        = 8'h46;
    localparam logic [7:0] KEY_H        = 8'h48;
    localparam logic [7:0] KEY_LBRACKET = 8'h5B;
    localparam logic [7:0] KEY_TILDE    = 8'd126;
    localparam logic [7:0] KEY_BS       = 8'd127;

    // result kinds
    localparam logic [1:0] KIND_STATUS = 2'd0;
    localparam logic [1:0] KIND_CHAR   = 2'd1;
    localparam logic [1:0] KIND_EMPTY  = 2'd2;

    // edit commands from the decoder
    typedef enum logic [3:0] {
        OP_NOP,
        OP_LEFT,
        OP_RIGHT,
        OP_HOME,
        OP_END,
        OP_DEL,
        OP_BKSP,
        OP_INS,
        OP_ENTER
    } t_op;

    // escape parser phase
    typedef enum logic [1:0] {
        PH_NORMAL,
        PH_ESC,
        PH_CSI,
        PH_DEL
    } t_phase;

    // editor sequencer state
    typedef enum logic [0:0] {
        BS_IDLE,
        BS_STREAM
    } t_bstate;

    typedef struct packed {
        t_op        op;
        logic [7:0] ch;
    } t_cmd;

    typedef struct packed {
        logic [1:0]       kind;
        logic [CNT_W-1:0] cur;
        logic [CNT_W-1:0] len;
        logic [7:0]       ch;
        logic             last;
    } t_result;

endpackage

// ----- src/tleb_queue.sv -----
module tleb_queue #(
    parameter int W = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_full,
    input  logic         i_pop,
    output logic [W-1:0] o_data,
    output logic         o_empty
);

    logic [W-1:0] r_mem [2];
    logic         r_wr;
    logic         r_rd;
    logic [1:0]   r_cnt;
    logic         n_wr;
    logic         n_rd;
    logic [1:0]   n_cnt;
    logic         do_push;
    logic         do_pop;

    // handshake qualification
    assign do_push = i_push && (r_cnt != 2'd2);
    assign do_pop  = i_pop && (r_cnt != 2'd0);
    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_data  = r_mem[r_rd];

    // pointer and count update
    always_comb begin
        n_wr  = do_push ? ~r_wr : r_wr;
        n_rd  = do_pop ? ~r_rd : r_rd;
        n_cnt = r_cnt + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

// ----- src/tleb_front.sv -----
module tleb_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [7:0]        i_key_byte,
    output tleb_pkg::t_cmd    o_cmd
);

    tleb_pkg::t_phase r_phase;
    tleb_pkg::t_phase n_phase;

    // escape parser next phase
    always_comb begin
        n_phase = r_phase;
        if (i_accept) begin
            unique case (r_phase)
                tleb_pkg::PH_NORMAL: begin
                    n_phase = (i_key_byte == tleb_pkg::KEY_ESC) ? tleb_pkg::PH_ESC
                                                                : tleb_pkg::PH_NORMAL;
                end
                tleb_pkg::PH_ESC: begin
                    n_phase = (i_key_byte == tleb_pkg::KEY_LBRACKET) ? tleb_pkg::PH_CSI
                                                                     : tleb_pkg::PH_NORMAL;
                end
                tleb_pkg::PH_CSI: begin
                    n_phase = (i_key_byte == tleb_pkg::KEY_THREE) ? tleb_pkg::PH_DEL
                                                                  : tleb_pkg::PH_NORMAL;
                end
                tleb_pkg::PH_DEL: begin
                    n_phase = tleb_pkg::PH_NORMAL;
                end
                default: begin
                    n_phase = tleb_pkg::PH_NORMAL;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= tleb_pkg::PH_NORMAL;
        end else begin
            r_phase <= n_phase;
        end
    end

    // byte classification into an edit command
    always_comb begin
        o_cmd.ch = i_key_byte;
        o_cmd.op = tleb_pkg::OP_NOP;
        unique case (r_phase)
            tleb_pkg::PH_NORMAL: begin
                unique case (i_key_byte) inside
                    tleb_pkg::KEY_BS: begin
                        o_cmd.op = tleb_pkg::OP_BKSP;
                    end
                    tleb_pkg::KEY_LF, tleb_pkg::KEY_CR: begin
                        o_cmd.op = tleb_pkg::OP_ENTER;
                    end
                    [tleb_pkg::KEY_SPACE:tleb_pkg::KEY_TILDE]: begin
                        o_cmd.op = tleb_pkg::OP_INS;
                    end
                    default: begin
                        o_cmd.op = tleb_pkg::OP_NOP;
                    end
                endcase
            end
            tleb_pkg::PH_CSI: begin
                unique case (i_key_byte)
                    tleb_pkg::KEY_D: o_cmd.op = tleb_pkg::OP_LEFT;
                    tleb_pkg::KEY_C: o_cmd.op = tleb_pkg::OP_RIGHT;
                    tleb_pkg::KEY_H: o_cmd.op = tleb_pkg::OP_HOME;
                    tleb_pkg::KEY_F: o_cmd.op = tleb_pkg::OP_END;
                    default:         o_cmd.op = tleb_pkg::OP_NOP;
                endcase
            end
            tleb_pkg::PH_DEL: begin
                o_cmd.op = tleb_pkg::OP_DEL;
            end
            default: begin
                o_cmd.op = tleb_pkg::OP_NOP;
            end
        endcase
    end

endmodule

// ----- src/tleb_back.sv -----
`include "terminal_line_edit_buffer_core_assert.svh"

module tleb_back #(
    parameter int LINE_WIDTH = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  tleb_pkg::t_cmd    i_cmd,
    input  logic              i_cmd_valid,
    output logic              o_cmd_pop,
    input  logic              i_res_full,
    output logic              o_res_push,
    output tleb_pkg::t_result o_res
);

    localparam int CW = tleb_pkg::CNT_W;
    localparam logic [CW-1:0] LEN_MAX = CW'(LINE_WIDTH);

    logic [7:0]        r_cells [LINE_WIDTH];
    logic [7:0]        n_cells [LINE_WIDTH];
    logic [CW-1:0]     r_cur;
    logic [CW-1:0]     n_cur;
    logic [CW-1:0]     r_len;
    logic [CW-1:0]     n_len;
    logic [CW-1:0]     r_cnt;
    logic [CW-1:0]     n_cnt;
    tleb_pkg::t_bstate r_state;
    tleb_pkg::t_bstate n_state;

    logic          go;
    logic          emit;
    logic          stream_end;
    logic          ins;
    logic          rem;
    logic [CW-1:0] rem_pos;

    // command take and stream step
    assign go         = (r_state == tleb_pkg::BS_IDLE) && i_cmd_valid && !i_res_full;
    assign emit       = (r_state == tleb_pkg::BS_STREAM) && !i_res_full;
    assign stream_end = emit && (r_cnt == CW'(1));

    // cursor and length after the edit
    always_comb begin
        n_cur   = r_cur;
        n_len   = r_len;
        ins     = 1'b0;
        rem     = 1'b0;
        rem_pos = r_cur;
        if (go) begin
            case (i_cmd.op)
                tleb_pkg::OP_LEFT: begin
                    if (r_cur != '0) n_cur = r_cur - CW'(1);
                end
                tleb_pkg::OP_RIGHT: begin
                    if (r_cur < r_len) n_cur = r_cur + CW'(1);
                end
                tleb_pkg::OP_HOME: begin
                    n_cur = '0;
                end
                tleb_pkg::OP_END: begin
                    n_cur = r_len;
                end
                tleb_pkg::OP_DEL: begin
                    if (r_cur < r_len) begin
                        rem   = 1'b1;
                        n_len = r_len - CW'(1);
                    end
                end
                tleb_pkg::OP_BKSP: begin
                    if (r_cur != '0) begin
                        rem     = 1'b1;
                        rem_pos = r_cur - CW'(1);
                        n_cur   = r_cur - CW'(1);
                        n_len   = r_len - CW'(1);
                    end
                end
                tleb_pkg::OP_INS: begin
                    if (r_len < LEN_MAX) begin
                        ins   = 1'b1;
                        n_cur = r_cur + CW'(1);
                        n_len = r_len + CW'(1);
                    end
                end
                default: begin
                end
            endcase
        end
        if (stream_end) begin
            n_cur = '0;
            n_len = '0;
        end
    end

    // per-cell next value: insert shifts up, delete and streaming shift down
    for (genvar i = 0; i < LINE_WIDTH; i++) begin : g_cell
        logic [7:0] from_below;
        logic [7:0] from_above;
        if (i == 0) begin : g_first
            assign from_below = r_cells[i];
        end else begin : g_rest
            assign from_below = r_cells[i-1];
        end
        if (i == LINE_WIDTH - 1) begin : g_top
            assign from_above = r_cells[i];
        end else begin : g_inner
            assign from_above = r_cells[i+1];
        end
        always_comb begin
            n_cells[i] = r_cells[i];
            if (ins && (CW'(i) == r_cur)) begin
                n_cells[i] = i_cmd.ch;
            end else if (ins && (CW'(i) > r_cur)) begin
                n_cells[i] = from_below;
            end else if (rem && (CW'(i) >= rem_pos)) begin
                n_cells[i] = from_above;
            end else if (emit) begin
                n_cells[i] = from_above;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < LINE_WIDTH; i++) begin
            r_cells[i] <= n_cells[i];
        end
    end

    // sequencer next state
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        unique case (r_state)
            tleb_pkg::BS_IDLE: begin
                if (go && (i_cmd.op == tleb_pkg::OP_ENTER) && (r_len != '0)) begin
                    n_state = tleb_pkg::BS_STREAM;
                    n_cnt   = r_len;
                end
            end
            tleb_pkg::BS_STREAM: begin
                if (emit) n_cnt = r_cnt - CW'(1);
                if (stream_end) n_state = tleb_pkg::BS_IDLE;
            end
            default: begin
                n_state = tleb_pkg::BS_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tleb_pkg::BS_IDLE;
            r_cur   <= '0;
            r_len   <= '0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cur   <= n_cur;
            r_len   <= n_len;
            r_cnt   <= n_cnt;
        end
    end

    // sequencer outputs
    always_comb begin
        o_cmd_pop  = 1'b0;
        o_res_push = 1'b0;
        o_res      = '{kind: tleb_pkg::KIND_STATUS, cur: n_cur, len: n_len,
                       ch: 8'd0, last: 1'b1};
        unique case (r_state)
            tleb_pkg::BS_IDLE: begin
                o_cmd_pop = go;
                if (go && (i_cmd.op == tleb_pkg::OP_ENTER)) begin
                    o_res_push = (r_len == '0);
                    o_res      = '{kind: tleb_pkg::KIND_EMPTY, cur: '0, len: '0,
                                   ch: 8'd0, last: 1'b1};
                end else begin
                    o_res_push = go;
                end
            end
            tleb_pkg::BS_STREAM: begin
                o_res_push = emit;
                o_res      = '{kind: tleb_pkg::KIND_CHAR, cur: '0, len: r_len,
                               ch: r_cells[0], last: (r_cnt == CW'(1))};
            end
            default: begin
            end
        endcase
    end

    `TLEB_ASSERT(a_cur_in_line, r_cur <= r_len, "cursor beyond end of line")
    `TLEB_ASSERT(a_len_in_width, r_len <= LEN_MAX, "line longer than line width")
    `TLEB_ASSERT(a_stream_cnt, (r_state != tleb_pkg::BS_STREAM) || ((r_cnt != '0) && (r_cnt <= r_len)), "stream count out of range")
    `TLEB_ASSERT(a_push_room, !o_res_push || !i_res_full, "result pushed into full queue")
    `TLEB_ASSERT_NEXT(a_stream_clear, stream_end, (r_state == tleb_pkg::BS_IDLE) && (r_len == '0) && (r_cur == '0), "line not cleared after stream")

endmodule

// ----- src/terminal_line_edit_buffer_core.sv -----
// channel   direction   handshake            words
// key in    input       push / full          i_key_byte
// result    output      empty / pop          o_result_kind o_cursor_pos o_line_length
//                                            o_text_char o_last
//
// a key byte is decoded in the cycle it is accepted and queued as an edit command
// the editor takes one command per cycle when not streaming and the result queue has room;
// a status word goes into the result queue as its command leaves the command queue
// enter streams the line at one character word per cycle while the result queue has room
// line cells shift in parallel, so each edit updates all cells with the cursor and length
// synchronous active-low reset clears the parser, cursor, length and both queues
// full rises when the command queue holds 2 words; pop backpressure stalls the editor
module terminal_line_edit_buffer_core #(
    parameter int LINE_WIDTH = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] i_key_byte,
    output logic       empty,
    input  logic       pop,
    output logic [1:0] o_result_kind,
    output logic [6:0] o_cursor_pos,
    output logic [6:0] o_line_length,
    output logic [7:0] o_text_char,
    output logic       o_last
);

    localparam int CMD_W = $bits(tleb_pkg::t_cmd);
    localparam int RES_W = $bits(tleb_pkg::t_result);

    logic              accept;
    tleb_pkg::t_cmd    front_cmd;
    logic [CMD_W-1:0]  cmdq_data;
    logic              cmdq_empty;
    logic              cmd_pop;
    logic              resq_full;
    logic              res_push;
    tleb_pkg::t_result back_res;
    logic [RES_W-1:0]  resq_data;
    tleb_pkg::t_result head;

    assign accept = push && !full;

    // decoder and escape parser
    tleb_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_key_byte (i_key_byte),
        .o_cmd      (front_cmd)
    );

    // command queue between decoder and editor
    tleb_queue #(
        .W (CMD_W)
    ) u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_data  (front_cmd),
        .o_full  (full),
        .i_pop   (cmd_pop),
        .o_data  (cmdq_data),
        .o_empty (cmdq_empty)
    );

    // line editor
    tleb_back #(
        .LINE_WIDTH (LINE_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (tleb_pkg::t_cmd'(cmdq_data)),
        .i_cmd_valid (!cmdq_empty),
        .o_cmd_pop   (cmd_pop),
        .i_res_full  (resq_full),
        .o_res_push  (res_push),
        .o_res       (back_res)
    );

    // result queue toward the consumer
    tleb_queue #(
        .W (RES_W)
    ) u_resq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (back_res),
        .o_full  (resq_full),
        .i_pop   (pop),
        .o_data  (resq_data),
        .o_empty (empty)
    );

    // result word fields
    assign head          = tleb_pkg::t_result'(resq_data);
    assign o_result_kind = head.kind;
    assign o_cursor_pos  = head.cur;
    assign o_line_length = head.len;
    assign o_text_char   = head.ch;
    assign o_last        = head.last;

endmodule
